// ----- hw/rtl/mtf_pkg.sv -----
package mtf_pkg;

    localparam int SYM_W = 8;
    localparam int ALPHABET_SIZE_DEF = 256;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // control broadcast from the sequencer to every cell of the ring
    typedef struct packed {
        logic shift;    // every cell takes its neighbor's value
        logic load_id;  // every cell reloads its identity value
        logic last;     // final shift of a pass, cell 0 takes the front value
    } mtf_cell_ctl_t;

endpackage

// ----- hw/rtl/mtf_cell.sv -----
module mtf_cell #(
    parameter logic [mtf_pkg::SYM_W-1:0] INIT = '0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mtf_pkg::mtf_cell_ctl_t       ctl,
    input  logic [mtf_pkg::SYM_W-1:0]    din,
    output logic [mtf_pkg::SYM_W-1:0]    q
);
    import mtf_pkg::*;

    logic [SYM_W-1:0] val_reg;
    logic [SYM_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load_id)
        begin
            val_next = INIT;
        end
        else if (ctl.shift)
        begin
            val_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= INIT;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign q = val_reg;

endmodule

// ----- hw/rtl/mtf_seq.sv -----
module mtf_seq #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mode,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic [mtf_pkg::SYM_W-1:0]    symbol_in,
    input  logic                         block_start,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic [mtf_pkg::SYM_W-1:0]    symbol_out,
    input  logic [mtf_pkg::SYM_W-1:0]    head,
    output logic [mtf_pkg::SYM_W-1:0]    tail,
    output logic [mtf_pkg::SYM_W-1:0]    front,
    output mtf_pkg::mtf_cell_ctl_t       ctl
);
    import mtf_pkg::*;

    localparam int IDX_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam logic [SYM_W:0] N_EXT = (SYM_W + 1)'(ALPHABET_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);
    localparam logic [SYM_W-1:0] BAD_RANK = SYM_W'(ALPHABET_SIZE);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [SYM_W-1:0] carry_reg, carry_next;
    logic [SYM_W-1:0] res_reg, res_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_data_reg, out_data_next;

    logic accept;
    logic in_range;
    logic match;
    logic last;

    assign src_stall = (state_reg != S_IDLE);
    assign accept    = src_valid && !src_stall;
    assign in_range  = ({1'b0, symbol_in} < N_EXT);
    assign last      = (cnt_reg == LAST_IDX);

    always_comb
    begin
        if (found_reg)
        begin
            match = 1'b0;
        end
        else if (mode == MODE_DEC)
        begin
            match = (cnt_reg == pos_reg);
        end
        else
        begin
            match = (head == sym_reg);
        end
    end

    // entries ahead of the hit move back by one through the carry
    assign tail  = found_reg ? head : carry_reg;
    assign front = (mode == MODE_DEC) ? (found_reg ? res_reg : head) : sym_reg;

    assign ctl.shift   = (state_reg == S_RUN);
    assign ctl.load_id = accept && block_start;
    assign ctl.last    = (state_reg == S_RUN) && last;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        sym_next       = sym_reg;
        carry_next     = carry_reg;
        res_next       = res_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next   = symbol_in;
                    carry_next = symbol_in;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    pos_next   = in_range ? symbol_in[IDX_W-1:0] : LAST_IDX;
                    if (mode == MODE_ENC && !in_range)
                    begin
                        res_next   = BAD_RANK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (!found_reg)
                begin
                    carry_next = head;
                end
                if (match)
                begin
                    found_next = 1'b1;
                    res_next   = (mode == MODE_DEC) ? head : SYM_W'(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !dst_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        sym_reg      <= sym_next;
        carry_reg    <= carry_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign dst_valid  = out_valid_reg;
    assign symbol_out = out_data_reg;

endmodule

// ----- hw/rtl/move_to_front_codec.sv -----
// Byte move-to-front codec. The recency list lives in a ring of ALPHABET_SIZE
// cells; for each item the ring makes one full rotation past a head unit that
// matches the byte (encode) or the rank (decode) and slips the entries ahead of
// the hit back by one. The ring rotates one cell per cycle, and no new item is
// taken until the current one is finished; an encode of a byte outside the
// alphabet skips the rotation, answers with rank ALPHABET_SIZE and leaves the
// list alone. block_start reloads the identity order at no extra cost. The
// finished result sits in an output register, so a new beat is taken while it
// waits. mode (0 encode, 1 decode) is written through the cfg channel, by the
// user only while the block is idle; the block itself does not enforce it.
module move_to_front_codec #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic [mtf_pkg::SYM_W-1:0]    symbol_in,
    input  logic                         block_start,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic [mtf_pkg::SYM_W-1:0]    symbol_out
);
    import mtf_pkg::*;

    logic             mode_reg;
    logic [SYM_W-1:0] cell_q [ALPHABET_SIZE];
    logic [SYM_W-1:0] tail;
    logic [SYM_W-1:0] front;
    mtf_cell_ctl_t    ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    mtf_seq #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode_reg),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .symbol_in   (symbol_in),
        .block_start (block_start),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .symbol_out  (symbol_out),
        .head        (cell_q[0]),
        .tail        (tail),
        .front       (front),
        .ctl         (ctl)
    );

    for (genvar k = 0; k < ALPHABET_SIZE; k++)
    begin : g_cell
        logic [SYM_W-1:0] din;

        if (k == ALPHABET_SIZE - 1)
        begin : g_tail
            assign din = tail;
        end
        else if (k == 0)
        begin : g_front
            assign din = ctl.last ? front : cell_q[1];
        end
        else
        begin : g_mid
            assign din = cell_q[k + 1];
        end

        mtf_cell #(
            .INIT (SYM_W'(k))
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .din   (din),
            .q     (cell_q[k])
        );
    end

endmodule

// ----- hw/rtl/mtf_checker.sv -----
module mtf_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         src_valid,
    input  logic                         src_stall,
    input  logic                         dst_valid,
    input  logic                         dst_stall,
    input  logic [mtf_pkg::SYM_W-1:0]    symbol_out
);

    // a held result beat keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(symbol_out))
        else $error("result beat changed while stalled");

    // one item in flight: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("input open right after accept");

    // a new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(src_stall))
        else $error("result without an item in flight");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .symbol_out (symbol_out)
);
